FILE: rtl/uer_pkg.sv
package uer_pkg;

    localparam int AVG_COUNT   = 100;

    localparam int TRIG_W      = 10;
    localparam int TIMEOUT_W   = 16;
    localparam int SCALE_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam int COUNT_W     = 17;
    localparam int SUM_W       = 21;
    localparam int SAMPLE_W    = 7;
    localparam int DIST_W      = 14;
    localparam int PROD_W      = COUNT_W + SCALE_W;
    localparam int SCALE_SHIFT = 12;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [TRIG_W-1:0]    TRIGGER_RESET      = TRIG_W'(10);
    localparam logic [TIMEOUT_W-1:0] RISE_TIMEOUT_RESET = TIMEOUT_W'(10000);
    localparam logic [TIMEOUT_W-1:0] HIGH_TIMEOUT_RESET = TIMEOUT_W'(50000);
    localparam logic [SCALE_W-1:0]   SCALE_RESET        = SCALE_W'(557);

    // mean by reciprocal multiplication, exact for every sum below 2**SUM_W
    localparam int AVG_SHIFT   = SUM_W + $clog2(AVG_COUNT);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int RECIP_LO_W  = RECIP_W / 2;
    localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
    localparam int PART_W      = SUM_W + RECIP_HI_W;
    localparam int FULL_W      = SUM_W + RECIP_W;
    localparam logic [63:0] AVG_RECIP64 =
        ((64'd1 << AVG_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
    localparam logic [RECIP_W-1:0] AVG_RECIP = AVG_RECIP64[RECIP_W-1:0];

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_HIGH
    } t_phase;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRIGGER,
        CFG_RISE_TIMEOUT,
        CFG_HIGH_TIMEOUT,
        CFG_SCALE
    } t_cfg_index;

    typedef struct packed {
        logic [TRIG_W-1:0]    trigger_ticks;
        logic [TIMEOUT_W-1:0] rise_timeout_ticks;
        logic [TIMEOUT_W-1:0] high_timeout_ticks;
        logic [SCALE_W-1:0]   distance_scale;
    } t_cfg;

    typedef struct packed {
        logic               trig;
        logic               done;
        logic [COUNT_W-1:0] count;
    } t_meas;

    typedef struct packed {
        logic              trig;
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_prod;

    typedef struct packed {
        logic              trig;
        logic              dvalid;
        logic [DIST_W-1:0] distance;
        logic              avalid;
        logic [SUM_W-1:0]  sum;
    } t_dist;

    typedef struct packed {
        logic              trig;
        logic              dvalid;
        logic [DIST_W-1:0] distance;
        logic              avalid;
        logic [PART_W-1:0] p_lo;
        logic [PART_W-1:0] p_hi;
    } t_part;

endpackage

FILE: rtl/uer_if.sv
interface uer_item_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_result_if import uer_pkg::*;;
    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic              distance_valid;
    logic [DIST_W-1:0] distance;
    logic              average_valid;
    logic [DIST_W-1:0] average;

    modport source (output valid, output trigger_level, output distance_valid,
                    output distance, output average_valid, output average, input ready);
    modport sink   (input valid, input trigger_level, input distance_valid,
                    input distance, input average_valid, input average, output ready);
endinterface

interface uer_cfg_if import uer_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/uer_step.sv
module uer_step import uer_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uer_item_if.sink  i_item,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    input  logic      i_ready,
    output t_meas     o_meas
);

    logic               r_in_valid;
    logic               r_start;
    logic               r_echo;
    t_phase             r_phase;
    logic [COUNT_W-1:0] r_ticks;
    logic               r_out_valid;
    t_meas              r_meas;

    t_phase             n_phase;
    logic [COUNT_W-1:0] n_ticks;
    t_meas              n_meas;

    logic               w_adv_out;
    logic               w_in_ready;
    logic [COUNT_W-1:0] w_inc;
    logic [COUNT_W-1:0] w_high_cnt;

    assign w_adv_out  = !r_out_valid || i_ready;
    assign w_in_ready = !r_in_valid || w_adv_out;
    assign i_item.ready = w_in_ready;
    assign o_valid = r_out_valid;
    assign o_meas  = r_meas;

    assign w_inc = r_ticks + COUNT_W'(1);
    // the rise tick is the first counted high tick
    assign w_high_cnt = (r_phase == PH_RISE) ? COUNT_W'(1) : w_inc;

    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_meas  = '0;
        case (r_phase)
            PH_IDLE: begin
                if (r_start) begin
                    n_meas.trig = 1'b1;
                    if (i_cfg.trigger_ticks <= TRIG_W'(1)) begin
                        n_phase = PH_RISE;
                        n_ticks = '0;
                    end else begin
                        n_phase = PH_TRIG;
                        n_ticks = COUNT_W'(1);
                    end
                end
            end
            PH_TRIG: begin
                n_meas.trig = 1'b1;
                if (w_inc >= COUNT_W'(i_cfg.trigger_ticks)) begin
                    n_phase = PH_RISE;
                    n_ticks = '0;
                end else begin
                    n_ticks = w_inc;
                end
            end
            PH_RISE, PH_HIGH: begin
                if (r_phase == PH_RISE && !r_echo) begin
                    if (w_inc >= COUNT_W'(i_cfg.rise_timeout_ticks)) begin
                        n_phase = PH_HIGH;
                        n_ticks = '0;
                    end else begin
                        n_ticks = w_inc;
                    end
                end else if (r_echo) begin
                    if (w_high_cnt >= COUNT_W'(i_cfg.high_timeout_ticks)) begin
                        n_meas.done  = 1'b1;
                        n_meas.count = w_high_cnt;
                        n_phase      = PH_IDLE;
                        n_ticks      = '0;
                    end else begin
                        n_phase = PH_HIGH;
                        n_ticks = w_high_cnt;
                    end
                end else begin
                    n_meas.done  = 1'b1;
                    n_meas.count = r_ticks;
                    n_phase      = PH_IDLE;
                    n_ticks      = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_ticks = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_ticks     <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_adv_out) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv_out && r_in_valid) begin
                r_phase <= n_phase;
                r_ticks <= n_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_item.valid) begin
            r_start <= i_item.start_req;
            r_echo  <= i_item.echo_level;
        end
        if (w_adv_out && r_in_valid) begin
            r_meas <= n_meas;
        end
    end

endmodule

FILE: rtl/uer_scale.sv
module uer_scale import uer_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_meas              i_meas,
    input  logic [SCALE_W-1:0] i_scale,
    output logic               o_valid,
    input  logic               i_ready,
    output t_dist              o_dist
);

    logic                r_a_valid;
    t_prod               r_a;
    logic                r_b_valid;
    t_dist               r_b;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_samples;

    t_prod               n_a;
    t_dist               n_b;

    logic                w_adv_a;
    logic                w_adv_b;
    logic [PROD_W-1:0]   w_shifted;
    logic [DIST_W-1:0]   w_dist;
    logic [SUM_W-1:0]    w_sum;
    logic [SAMPLE_W-1:0] w_samples;
    logic                w_avg_done;

    assign w_adv_b = !r_b_valid || i_ready;
    assign w_adv_a = !r_a_valid || w_adv_b;
    assign o_ready = w_adv_a;
    assign o_valid = r_b_valid;
    assign o_dist  = r_b;

    assign n_a.trig = i_meas.trig;
    assign n_a.done = i_meas.done;
    assign n_a.prod = PROD_W'(i_meas.count) * PROD_W'(i_scale);

    assign w_shifted  = r_a.prod >> SCALE_SHIFT;
    assign w_dist     = (w_shifted > PROD_W'(DIST_MAX)) ? DIST_MAX : w_shifted[DIST_W-1:0];
    assign w_sum      = r_sum + SUM_W'(w_dist);
    assign w_samples  = r_samples + SAMPLE_W'(1);
    assign w_avg_done = w_samples >= SAMPLE_W'(AVG_COUNT);

    assign n_b.trig     = r_a.trig;
    assign n_b.dvalid   = r_a.done;
    assign n_b.distance = r_a.done ? w_dist : '0;
    assign n_b.avalid   = r_a.done && w_avg_done;
    assign n_b.sum      = (r_a.done && w_avg_done) ? w_sum : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_sum     <= '0;
            r_samples <= '0;
        end else begin
            if (w_adv_a) begin
                r_a_valid <= i_valid;
            end
            if (w_adv_b) begin
                r_b_valid <= r_a_valid;
            end
            // running sum, cleared once a mean is taken
            if (w_adv_b && r_a_valid && r_a.done) begin
                if (w_avg_done) begin
                    r_sum     <= '0;
                    r_samples <= '0;
                end else begin
                    r_sum     <= w_sum;
                    r_samples <= w_samples;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_a <= n_a;
        end
        if (w_adv_b && r_a_valid) begin
            r_b <= n_b;
        end
    end

endmodule

FILE: rtl/uer_average.sv
module uer_average import uer_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_dist        i_dist,
    uer_result_if.source o_result
);

    logic              r_c_valid;
    t_part             r_c;
    logic              r_out_valid;
    logic              r_trig;
    logic              r_dvalid;
    logic [DIST_W-1:0] r_dist;
    logic              r_avalid;
    logic [DIST_W-1:0] r_avg;

    t_part             n_c;
    logic [DIST_W-1:0] n_avg;

    logic              w_adv_c;
    logic              w_adv_out;
    logic [FULL_W-1:0] w_full;
    logic [FULL_W-1:0] w_quot;

    assign w_adv_out = !r_out_valid || o_result.ready;
    assign w_adv_c   = !r_c_valid || w_adv_out;
    assign o_ready   = w_adv_c;

    // reciprocal split in two halves so each product stays within 32 bits
    assign n_c.trig     = i_dist.trig;
    assign n_c.dvalid   = i_dist.dvalid;
    assign n_c.distance = i_dist.distance;
    assign n_c.avalid   = i_dist.avalid;
    assign n_c.p_lo     = PART_W'(i_dist.sum) * PART_W'(AVG_RECIP[RECIP_LO_W-1:0]);
    assign n_c.p_hi     = PART_W'(i_dist.sum) * PART_W'(AVG_RECIP[RECIP_W-1:RECIP_LO_W]);

    assign w_full = (FULL_W'(r_c.p_hi) << RECIP_LO_W) + FULL_W'(r_c.p_lo);
    assign w_quot = w_full >> AVG_SHIFT;
    assign n_avg  = !r_c.avalid ? '0 :
                    (w_quot > FULL_W'(DIST_MAX)) ? DIST_MAX : w_quot[DIST_W-1:0];

    assign o_result.valid          = r_out_valid;
    assign o_result.trigger_level  = r_trig;
    assign o_result.distance_valid = r_dvalid;
    assign o_result.distance       = r_dist;
    assign o_result.average_valid  = r_avalid;
    assign o_result.average        = r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv_c) begin
                r_c_valid <= i_valid;
            end
            if (w_adv_out) begin
                r_out_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_c && i_valid) begin
            r_c <= n_c;
        end
        if (w_adv_out && r_c_valid) begin
            r_trig   <= r_c.trig;
            r_dvalid <= r_c.dvalid;
            r_dist   <= r_c.distance;
            r_avalid <= r_c.avalid;
            r_avg    <= n_avg;
        end
    end

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger. Each input word is one microsecond tick carrying a
// start request and the sampled echo level; each tick gives exactly one result
// word with the trigger level, a distance in 1/8 cm when a measurement ends
// (count * distance_scale >> 12, saturated at 16383) and, every AVG_COUNT
// distances, their truncated mean. Unless the result channel stalls, one
// input word is taken every clock; each tick passes the input, tick-count
// phase, scaling multiplier, running sum, two-step reciprocal multiply and
// result registers. Back-pressure on the result channel stalls the pipeline
// stage by stage. Configuration writes are always accepted and must only be
// made while no ticks are in flight.
module ultrasonic_echo_ranger import uer_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    uer_item_if.sink     i_item,
    uer_cfg_if.sink      i_cfg,
    uer_result_if.source o_result
);

    t_cfg  r_cfg;

    logic  w_meas_valid;
    logic  w_meas_ready;
    t_meas w_meas;
    logic  w_dist_valid;
    logic  w_dist_ready;
    t_dist w_dist;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks      <= TRIGGER_RESET;
            r_cfg.rise_timeout_ticks <= RISE_TIMEOUT_RESET;
            r_cfg.high_timeout_ticks <= HIGH_TIMEOUT_RESET;
            r_cfg.distance_scale     <= SCALE_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_TRIGGER:      r_cfg.trigger_ticks      <= i_cfg.data[TRIG_W-1:0];
                CFG_RISE_TIMEOUT: r_cfg.rise_timeout_ticks <= i_cfg.data[TIMEOUT_W-1:0];
                CFG_HIGH_TIMEOUT: r_cfg.high_timeout_ticks <= i_cfg.data[TIMEOUT_W-1:0];
                CFG_SCALE:        r_cfg.distance_scale     <= i_cfg.data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uer_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (w_meas_valid),
        .i_ready (w_meas_ready),
        .o_meas  (w_meas)
    );

    uer_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_meas_valid),
        .o_ready (w_meas_ready),
        .i_meas  (w_meas),
        .i_scale (r_cfg.distance_scale),
        .o_valid (w_dist_valid),
        .i_ready (w_dist_ready),
        .o_dist  (w_dist)
    );

    uer_average u_average (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_dist_valid),
        .o_ready  (w_dist_ready),
        .i_dist   (w_dist),
        .o_result (o_result)
    );

    // trigger phases never end a measurement
    a_done_no_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_meas_valid && w_meas.done |-> !w_meas.trig)
        else $error("measurement finished while trigger driven");

    a_avg_with_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.average_valid |-> o_result.distance_valid)
        else $error("average given without a distance");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.distance_valid |->
            (o_result.distance == '0) && (o_result.average == '0) && !o_result.average_valid)
        else $error("result fields not cleared without a measurement");

    a_avg_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist_valid && !w_dist.avalid |-> w_dist.sum == '0)
        else $error("sum passed on without an average");

endmodule
